FILE: hw/rtl/spsc_pkg.sv
// Shared types and constants for the segmented prime sieve counter.
// Used by the controller, the datapath and the top level.
package spsc_pkg;

    // Field widths and sieve geometry
    localparam int VAL_W      = 24;
    localparam int CNT_W      = 25;
    localparam int SEG_SIZE   = 4096;
    localparam int SEG_AW     = $clog2(SEG_SIZE);
    localparam int ROOT_W     = 12;
    localparam int BASE_DEPTH = 4096;
    localparam int BASE_AW    = $clog2(BASE_DEPTH);
    localparam int SQBIT_W    = 4;
    localparam int DIVCNT_W   = 5;

    localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [SQBIT_W-1:0] SQBIT_TOP = SQBIT_W'(ROOT_W - 1);
    localparam logic [DIVCNT_W-1:0] DIV_TOP  = DIVCNT_W'(VAL_W - 1);
    localparam logic [VAL_W-1:0]   SPAN_MAX  = VAL_W'(SEG_SIZE - 1);

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_SQ_MUL,
        S_SQ_CMP,
        S_BCLR,
        S_BP_INIT,
        S_BP_SQ,
        S_BP_CHK,
        S_BP_RD,
        S_BP_MARK,
        S_SEG_INIT,
        S_SCLR,
        S_SP_INIT,
        S_SP_CHK,
        S_SP_RD,
        S_DIV,
        S_SP_FIRST,
        S_SP_MAX,
        S_SP_MARK,
        S_CNT_RD,
        S_CNT_ACC,
        S_SEG_NEXT,
        S_RESULT
    } state_t;

    // Datapath commands
    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_SQ_MUL,
        CMD_SQ_CMP,
        CMD_BCLR,
        CMD_BP_INIT,
        CMD_BP_SQ,
        CMD_BP_READ,
        CMD_BP_TEST,
        CMD_BP_MARK,
        CMD_SEG_INIT,
        CMD_SCLR,
        CMD_SP_INIT,
        CMD_SP_READ,
        CMD_SP_TEST,
        CMD_DIV,
        CMD_SP_FIRST,
        CMD_SP_MAX,
        CMD_SP_MARK,
        CMD_CNT_READ,
        CMD_CNT_ACC,
        CMD_SEG_NEXT,
        CMD_RESULT
    } cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic lo_gt_hi;
        logic sqbit_zero;
        logic ptr_eq_root;
        logic psq_gt_root;
        logic base_flag;
        logic q_gt_root;
        logic p_gt_root;
        logic div_done;
        logic j_gt_end;
        logic ptr_eq_span;
        logic end_eq_hi;
        logic out_busy;
    } status_t;

endpackage

FILE: hw/rtl/spsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/spsc_ctrl.sv
// Sequencer for the sieve: square root, base sieve, per-segment marking and count.
// Depends on spsc_pkg; drives spsc_dp through cmd_t and reads status_t.
module spsc_ctrl
    import spsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = st.lo_gt_hi ? S_RESULT : S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd        = CMD_SQ_MUL;
                state_next = S_SQ_CMP;
            end
            S_SQ_CMP:
            begin
                cmd        = CMD_SQ_CMP;
                state_next = st.sqbit_zero ? S_BCLR : S_SQ_MUL;
            end
            S_BCLR:
            begin
                cmd        = CMD_BCLR;
                state_next = st.ptr_eq_root ? S_BP_INIT : S_BCLR;
            end
            S_BP_INIT:
            begin
                cmd        = CMD_BP_INIT;
                state_next = S_BP_SQ;
            end
            S_BP_SQ:
            begin
                cmd        = CMD_BP_SQ;
                state_next = S_BP_CHK;
            end
            S_BP_CHK:
            begin
                cmd        = CMD_BP_READ;
                state_next = st.psq_gt_root ? S_SEG_INIT : S_BP_RD;
            end
            S_BP_RD:
            begin
                cmd        = CMD_BP_TEST;
                state_next = st.base_flag ? S_BP_MARK : S_BP_SQ;
            end
            S_BP_MARK:
            begin
                cmd        = CMD_BP_MARK;
                state_next = st.q_gt_root ? S_BP_SQ : S_BP_MARK;
            end
            S_SEG_INIT:
            begin
                cmd        = CMD_SEG_INIT;
                state_next = S_SCLR;
            end
            S_SCLR:
            begin
                cmd        = CMD_SCLR;
                state_next = st.ptr_eq_span ? S_SP_INIT : S_SCLR;
            end
            S_SP_INIT:
            begin
                cmd        = CMD_SP_INIT;
                state_next = S_SP_CHK;
            end
            S_SP_CHK:
            begin
                cmd        = CMD_SP_READ;
                state_next = st.p_gt_root ? S_CNT_RD : S_SP_RD;
            end
            S_SP_RD:
            begin
                cmd        = CMD_SP_TEST;
                state_next = st.base_flag ? S_DIV : S_SP_CHK;
            end
            S_DIV:
            begin
                cmd        = CMD_DIV;
                state_next = st.div_done ? S_SP_FIRST : S_DIV;
            end
            S_SP_FIRST:
            begin
                cmd        = CMD_SP_FIRST;
                state_next = S_SP_MAX;
            end
            S_SP_MAX:
            begin
                cmd        = CMD_SP_MAX;
                state_next = S_SP_MARK;
            end
            S_SP_MARK:
            begin
                cmd        = CMD_SP_MARK;
                state_next = st.j_gt_end ? S_SP_CHK : S_SP_MARK;
            end
            S_CNT_RD:
            begin
                cmd        = CMD_CNT_READ;
                state_next = S_CNT_ACC;
            end
            S_CNT_ACC:
            begin
                cmd        = CMD_CNT_ACC;
                state_next = st.ptr_eq_span ? S_SEG_NEXT : S_CNT_RD;
            end
            S_SEG_NEXT:
            begin
                cmd        = CMD_SEG_NEXT;
                state_next = st.end_eq_hi ? S_RESULT : S_SEG_INIT;
            end
            S_RESULT:
            begin
                if (!st.out_busy)
                begin
                    cmd        = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/spsc_dp.sv
// Datapath: bound registers, square root, divider, sieve stores, counter, output register.
// Depends on spsc_pkg and spsc_ram; commanded by spsc_ctrl.
module spsc_dp
    import spsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          st,
    input  logic [VAL_W-1:0] range_low,
    input  logic [VAL_W-1:0] range_high,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CNT_W-1:0] prime_count,
    output logic             range_error
);

    // request and sieve registers
    logic [VAL_W-1:0]    lo_reg, hi_reg, start_reg, end_reg;
    logic [SEG_AW-1:0]   span_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQBIT_W-1:0]  sqbit_reg;
    logic [VAL_W-1:0]    sq_reg;
    logic [ROOT_W-1:0]   ptr_reg;
    logic [ROOT_W:0]     p_reg;
    logic [ROOT_W:0]     q_reg;
    logic [VAL_W-1:0]    psq_reg;
    logic [ROOT_W-1:0]   rem_reg;
    logic [VAL_W-1:0]    dvd_reg;
    logic [DIVCNT_W-1:0] divcnt_reg;
    logic [CNT_W-1:0]    first_reg, j_reg;
    logic [CNT_W-1:0]    count_reg;

    // output register
    logic                out_valid_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_error_reg;

    // memory ports
    logic                base_we, base_wd, base_rd;
    logic [BASE_AW-1:0]  base_wa;
    logic                base_flag;
    logic                seg_we, seg_wd, seg_rd;
    logic [SEG_AW-1:0]   seg_wa;

    // combinational helpers
    logic [ROOT_W-1:0]   trial;
    logic [VAL_W-1:0]    trial_sq, p_sq;
    logic [ROOT_W:0]     div_t;
    logic [ROOT_W:0]     p_minus_rem;
    logic [VAL_W-1:0]    seg_diff;
    logic                seg_big;
    logic [CNT_W-1:0]    j_off;
    logic [CNT_W-1:0]    num_k;

    assign trial       = root_reg | (ROOT_W'(1) << sqbit_reg);
    assign trial_sq    = {{(VAL_W-ROOT_W){1'b0}}, trial} * {{(VAL_W-ROOT_W){1'b0}}, trial};
    assign p_sq        = {{(VAL_W-ROOT_W){1'b0}}, p_reg[ROOT_W-1:0]}
                       * {{(VAL_W-ROOT_W){1'b0}}, p_reg[ROOT_W-1:0]};
    assign div_t       = {rem_reg, dvd_reg[VAL_W-1]};
    assign p_minus_rem = p_reg - {1'b0, rem_reg};
    assign seg_diff    = hi_reg - start_reg;
    assign seg_big     = (seg_diff > SPAN_MAX);
    assign j_off       = j_reg - {1'b0, start_reg};
    assign num_k       = {1'b0, start_reg} + {{(CNT_W-ROOT_W){1'b0}}, ptr_reg};

    // base prime flags
    spsc_ram #(.WIDTH(1), .DEPTH(BASE_DEPTH)) u_base_ram (
        .clk     (clk),
        .wr_en   (base_we),
        .wr_addr (base_wa),
        .wr_data (base_wd),
        .rd_en   (base_rd),
        .rd_addr (p_reg[BASE_AW-1:0]),
        .rd_data (base_flag)
    );

    // segment flags
    logic seg_flag;
    spsc_ram #(.WIDTH(1), .DEPTH(SEG_SIZE)) u_seg_ram (
        .clk     (clk),
        .wr_en   (seg_we),
        .wr_addr (seg_wa),
        .wr_data (seg_wd),
        .rd_en   (seg_rd),
        .rd_addr (ptr_reg[SEG_AW-1:0]),
        .rd_data (seg_flag)
    );

    // memory port control
    always_comb
    begin
        base_we = 1'b0;
        base_wa = ptr_reg[BASE_AW-1:0];
        base_wd = 1'b1;
        base_rd = (cmd == CMD_BP_READ) || (cmd == CMD_SP_READ);
        seg_we  = 1'b0;
        seg_wa  = ptr_reg[SEG_AW-1:0];
        seg_wd  = 1'b1;
        seg_rd  = (cmd == CMD_CNT_READ);
        if (cmd == CMD_BCLR)
        begin
            base_we = 1'b1;
        end
        if ((cmd == CMD_BP_MARK) && !st.q_gt_root)
        begin
            base_we = 1'b1;
            base_wa = q_reg[BASE_AW-1:0];
            base_wd = 1'b0;
        end
        if (cmd == CMD_SCLR)
        begin
            seg_we = 1'b1;
        end
        if ((cmd == CMD_SP_MARK) && !st.j_gt_end)
        begin
            seg_we = 1'b1;
            seg_wa = j_off[SEG_AW-1:0];
            seg_wd = 1'b0;
        end
    end

    // status
    always_comb
    begin
        st.lo_gt_hi    = (lo_reg > hi_reg);
        st.sqbit_zero  = (sqbit_reg == '0);
        st.ptr_eq_root = (ptr_reg == root_reg);
        st.psq_gt_root = (psq_reg > {{(VAL_W-ROOT_W){1'b0}}, root_reg});
        st.base_flag   = base_flag;
        st.q_gt_root   = (q_reg > {1'b0, root_reg});
        st.p_gt_root   = (p_reg > {1'b0, root_reg});
        st.div_done    = (divcnt_reg == '0);
        st.j_gt_end    = (j_reg > {1'b0, end_reg});
        st.ptr_eq_span = (ptr_reg[SEG_AW-1:0] == span_reg);
        st.end_eq_hi   = (end_reg == hi_reg);
        st.out_busy    = out_valid_reg && out_stall;
    end

    // datapath registers, one command per cycle
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                lo_reg    <= range_low;
                hi_reg    <= range_high;
                start_reg <= range_low;
                root_reg  <= '0;
                sqbit_reg <= SQBIT_TOP;
                ptr_reg   <= '0;
                count_reg <= '0;
            end
            CMD_SQ_MUL:
            begin
                sq_reg <= trial_sq;
            end
            CMD_SQ_CMP:
            begin
                if (sq_reg <= hi_reg)
                begin
                    root_reg <= trial;
                end
                sqbit_reg <= sqbit_reg - SQBIT_W'(1);
            end
            CMD_BCLR:
            begin
                if (!st.ptr_eq_root)
                begin
                    ptr_reg <= ptr_reg + ROOT_W'(1);
                end
            end
            CMD_BP_INIT, CMD_SP_INIT:
            begin
                p_reg   <= (ROOT_W+1)'(2);
                ptr_reg <= '0;
            end
            CMD_BP_SQ:
            begin
                psq_reg <= p_sq;
            end
            CMD_BP_READ, CMD_SP_READ, CMD_CNT_READ, CMD_NOP:
            begin
            end
            CMD_BP_TEST:
            begin
                if (st.base_flag)
                begin
                    q_reg <= psq_reg[ROOT_W:0];
                end
                else
                begin
                    p_reg <= p_reg + (ROOT_W+1)'(1);
                end
            end
            CMD_BP_MARK:
            begin
                if (st.q_gt_root)
                begin
                    p_reg <= p_reg + (ROOT_W+1)'(1);
                end
                else
                begin
                    q_reg <= q_reg + p_reg;
                end
            end
            CMD_SEG_INIT:
            begin
                span_reg <= seg_big ? SPAN_MAX[SEG_AW-1:0] : seg_diff[SEG_AW-1:0];
                end_reg  <= seg_big ? (start_reg + SPAN_MAX) : hi_reg;
                ptr_reg  <= '0;
            end
            CMD_SCLR:
            begin
                ptr_reg <= ptr_reg + ROOT_W'(1);
            end
            CMD_SP_TEST:
            begin
                if (st.base_flag)
                begin
                    dvd_reg    <= start_reg;
                    rem_reg    <= '0;
                    divcnt_reg <= DIV_TOP;
                    psq_reg    <= p_sq;
                end
                else
                begin
                    p_reg <= p_reg + (ROOT_W+1)'(1);
                end
            end
            CMD_DIV:
            begin
                // one restoring step: start mod p
                if (div_t >= p_reg)
                begin
                    rem_reg <= ROOT_W'(div_t - p_reg);
                end
                else
                begin
                    rem_reg <= div_t[ROOT_W-1:0];
                end
                dvd_reg    <= {dvd_reg[VAL_W-2:0], 1'b0};
                divcnt_reg <= divcnt_reg - DIVCNT_W'(1);
            end
            CMD_SP_FIRST:
            begin
                // first multiple of p at or above the segment start
                first_reg <= {1'b0, start_reg}
                           + ((rem_reg == '0) ? '0
                              : {{(CNT_W-ROOT_W-1){1'b0}}, p_minus_rem});
            end
            CMD_SP_MAX:
            begin
                j_reg <= (first_reg < {1'b0, psq_reg}) ? {1'b0, psq_reg} : first_reg;
            end
            CMD_SP_MARK:
            begin
                if (st.j_gt_end)
                begin
                    p_reg <= p_reg + (ROOT_W+1)'(1);
                end
                else
                begin
                    j_reg <= j_reg + {{(CNT_W-ROOT_W-1){1'b0}}, p_reg};
                end
            end
            CMD_CNT_ACC:
            begin
                if (seg_flag && (num_k >= CNT_W'(2)) && (count_reg != COUNT_MAX))
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                ptr_reg <= ptr_reg + ROOT_W'(1);
            end
            CMD_SEG_NEXT:
            begin
                start_reg <= end_reg + VAL_W'(1);
            end
            CMD_RESULT:
            begin
                out_count_reg <= count_reg;
                out_error_reg <= st.lo_gt_hi;
            end
            default:
            begin
            end
        endcase
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd == CMD_RESULT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime_count = out_count_reg;
    assign range_error = out_error_reg;

endmodule

FILE: hw/rtl/segmented_prime_sieve_counter.sv
// Segmented prime sieve counter: counts primes in [range_low, range_high], one request at a time.
// After acceptance the block finds root = isqrt(high), sieves the base primes up to root, then for each
// segment clears its flags, strikes the multiples of every base prime and counts what is left;
// a reversed range skips all of this and goes straight to the result.
// Throughput: the next request is taken in the cycle its predecessor's result is presented.
// Reset (rst_n, async) idles the sequencer and empties the output register; no clearing pass.
module segmented_prime_sieve_counter
    import spsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [VAL_W-1:0] range_low,
    input  logic [VAL_W-1:0] range_high,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CNT_W-1:0] prime_count,
    output logic             range_error
);

    cmd_t    cmd;
    status_t st;

    // sequencer
    spsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath and stores
    spsc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .range_low   (range_low),
        .range_high  (range_high),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .prime_count (prime_count),
        .range_error (range_error)
    );

endmodule

FILE: hw/rtl/spsc_checker.sv
// Port-level checks for the segmented prime sieve counter, bound to the top level.
// Depends on spsc_pkg.
module spsc_checker
    import spsc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [CNT_W-1:0] prime_count,
    input logic             range_error
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prime_count) && $stable(range_error))
        else $error("result changed while stalled");

    // a refused request reports a zero count
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> prime_count == '0)
        else $error("error result with nonzero count");

    // a new request blocks the input until its result is out
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after request");

    // results appear only while a request is in progress
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a request in progress");

endmodule

bind segmented_prime_sieve_counter spsc_checker u_spsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prime_count (prime_count),
    .range_error (range_error)
);
